// ===== rtl/bfmc_pkg.sv =====
// shared constants, types and helpers of the box filter mip chain
package bfmc_pkg;

  localparam int MaxDim    = 256;
  localparam int MaxLevels = 8;

  localparam int DimW   = 9;
  localparam int CoordW = 7;
  localparam int LevelW = 4;
  localparam int ChanW  = 8;
  localparam int HsumW  = 10;

  localparam logic [1:0] AddrWidth  = 2'd0;
  localparam logic [1:0] AddrHeight = 2'd1;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic [ChanW-1:0] a;
  } pix_t;

  typedef struct packed {
    logic [HsumW-1:0] r;
    logic [HsumW-1:0] g;
    logic [HsumW-1:0] b;
    logic [HsumW-1:0] a;
  } hsum_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    pix_t              pix;
    logic              last;
    logic              done;
  } res_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] t;
    t = v;
    if (v == '0) t = DimW'(1);
    else if (v > maxv) t = maxv;
    return t;
  endfunction

  function automatic logic [DimW-1:0] half_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] t;
    t = v >> 1;
    if (t == '0) t = DimW'(1);
    return t;
  endfunction

  function automatic logic [HsumW-1:0] ext8(input logic [ChanW-1:0] v);
    return {{(HsumW-ChanW){1'b0}}, v};
  endfunction

  function automatic logic [ChanW-1:0] avg(input logic [HsumW-1:0] a,
                                           input logic [HsumW-1:0] b);
    logic [HsumW+1:0] s;
    s = {2'b00, a} + {2'b00, b} + (HsumW+2)'(2);
    return s[ChanW+1:2];
  endfunction

endpackage

// ===== rtl/box_filter_mip_chain.sv =====
// top level of the 2x2 box filter mip chain generator
// Takes RGBA8 base pixels in raster order and streams out every lower mip level
// down to 1x1, each result tagged with level, column and row. The front part
// is an input queue of four words; the back part walks one accepted pixel down
// the levels one level at a time. A pixel is accepted in the idle state, and each
// level visited takes a step state, plus a pending row-sum memory read state and
// an emit state when that level yields a pixel (no read state on single-row
// levels). One input yields up to 8 results, and a full output queue of four
// words adds stalls.
// The pending row sums live in one 256 x 40 ram with registered read;
// its entries are always written before they are read within a pass, so it
// needs no clearing after reset. Writing a size register restarts the image.
module box_filter_mip_chain #(
  parameter int MaxDim    = bfmc_pkg::MaxDim,
  parameter int MaxLevels = bfmc_pkg::MaxLevels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  // mip result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  level_o,
  output logic [6:0]  column_o,
  output logic [6:0]  row_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic        last_of_run_o,
  output logic        chain_done_o
);
  logic [bfmc_pkg::DimW-1:0] width_q, height_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'b0) begin
      if (paddr[1:0] == 2'b00 && 2'(paddr[2:2]) == bfmc_pkg::AddrWidth)
        prdata = 32'(width_q);
      else if (paddr[1:0] == 2'b00)
        prdata = '0;
    end else if (paddr[1:0] == 2'b00 && 2'(paddr[2:2]) == bfmc_pkg::AddrHeight) begin
      prdata = 32'(height_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bfmc_pkg::DimW'(1);
      height_q <= bfmc_pkg::DimW'(1);
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (2'(paddr[2:2]) == bfmc_pkg::AddrWidth) width_q <= pwdata[8:0];
      else height_q <= pwdata[8:0];
    end
  end

  // front queue
  bfmc_pkg::pix_t in_pix, q_pix;
  logic q_valid, q_stall;
  assign in_pix = '{r: red_i, g: green_i, b: blue_i, a: alpha_i};

  bfmc_fifo #(.Width($bits(bfmc_pkg::pix_t)), .Depth(4)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_pix),
    .out_valid_o(q_valid),
    .out_stall_i(q_stall),
    .out_data_o (q_pix)
  );

  // back engine
  bfmc_pkg::res_t res, oq;
  logic res_valid, res_stall;

  bfmc_back #(.MaxDim(MaxDim), .MaxLevels(MaxLevels)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .height_i   (height_q),
    .restart_i  (wr && paddr[1:0] == 2'b00),
    .in_valid_i (q_valid),
    .in_stall_o (q_stall),
    .in_pix_i   (q_pix),
    .res_valid_o(res_valid),
    .res_stall_i(res_stall),
    .res_o      (res)
  );

  // output queue absorbs cascades
  bfmc_fifo #(.Width($bits(bfmc_pkg::res_t)), .Depth(4)) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_stall_o (res_stall),
    .in_data_i  (res),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (oq)
  );

  assign level_o       = oq.level;
  assign column_o      = oq.column;
  assign row_o         = oq.row;
  assign out_red_o     = oq.pix.r;
  assign out_green_o   = oq.pix.g;
  assign out_blue_o    = oq.pix.b;
  assign out_alpha_o   = oq.pix.a;
  assign last_of_run_o = oq.last;
  assign chain_done_o  = oq.done;
endmodule

// ===== rtl/bfmc_ram.sv =====
// generic single-port write, single-port registered-read ram
module bfmc_ram #(
  parameter int Width = 40,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/bfmc_fifo.sv =====
// small fifo of words with valid and stall on both sides
module bfmc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [Width-1:0] out_data_o
);
  localparam int AW = $clog2(Depth);
  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign in_stall_o  = (cnt_q == (AW+1)'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + AW'(1);
      if (pop)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== rtl/bfmc_back.sv =====
// cascade engine: walks one pixel down the levels, one level step at a time
module bfmc_back #(
  parameter int MaxDim    = bfmc_pkg::MaxDim,
  parameter int MaxLevels = bfmc_pkg::MaxLevels
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [bfmc_pkg::DimW-1:0] width_i,
  input  logic [bfmc_pkg::DimW-1:0] height_i,
  input  logic                  restart_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bfmc_pkg::pix_t        in_pix_i,
  output logic                  res_valid_o,
  input  logic                  res_stall_i,
  output bfmc_pkg::res_t        res_o
);
  localparam int LW = $clog2(MaxLevels + 1);
  localparam int AW = $clog2(MaxDim);
  localparam int DW = bfmc_pkg::DimW;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StStep  = 4'b0010,
    StRead  = 4'b0100,
    StEmit  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // per level geometry, rebuilt combinationally from the registers
  logic [DW-1:0] lw [MaxLevels+2];
  logic [DW-1:0] lh [MaxLevels+2];
  logic [DW:0]   loff [MaxLevels+1];
  logic [LW-1:0] nlev;

  always_comb begin
    lw[0] = bfmc_pkg::clamp_dim(width_i, DW'(MaxDim));
    lh[0] = bfmc_pkg::clamp_dim(height_i, DW'(MaxDim));
    loff[0] = '0;
    nlev = LW'(MaxLevels);
    for (int k = 0; k < MaxLevels + 1; k++) begin
      lw[k+1] = bfmc_pkg::half_dim(lw[k]);
      lh[k+1] = bfmc_pkg::half_dim(lh[k]);
    end
    for (int k = 0; k < MaxLevels; k++) begin
      loff[k+1] = loff[k] + {1'b0, lw[k+1]};
    end
    for (int k = MaxLevels - 1; k >= 0; k--) begin
      if (lw[k] == DW'(1) && lh[k] == DW'(1)) nlev = LW'(k);
    end
  end

  logic [DW-1:0] col_q [MaxLevels];
  logic [DW-1:0] row_q [MaxLevels];
  bfmc_pkg::pix_t held_q [MaxLevels];

  logic [LW-1:0]  k_q;
  bfmc_pkg::pix_t p_q;
  bfmc_pkg::hsum_t hs_q;
  logic [DW-1:0]  x_q, y_q;

  // current level values
  logic [DW-1:0] w, h, dw, dh, c, r, x, y;
  logic [DW:0]   idx;
  bfmc_pkg::hsum_t hs;
  logic          stop, need_read, store;

  always_comb begin
    w  = lw[k_q[LW-1:0]];
    h  = lh[k_q];
    dw = lw[k_q + LW'(1)];
    dh = lh[k_q + LW'(1)];
    c  = col_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]];
    r  = row_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]];
    x  = (w == DW'(1)) ? '0 : (c >> 1);
    y  = (h == DW'(1)) ? '0 : (r >> 1);
    idx = loff[k_q] + {1'b0, x};
    hs = '0;
    if (w == DW'(1)) begin
      hs.r = bfmc_pkg::ext8(p_q.r) << 1;
      hs.g = bfmc_pkg::ext8(p_q.g) << 1;
      hs.b = bfmc_pkg::ext8(p_q.b) << 1;
      hs.a = bfmc_pkg::ext8(p_q.a) << 1;
    end else begin
      hs.r = bfmc_pkg::ext8(held_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]].r)
             + bfmc_pkg::ext8(p_q.r);
      hs.g = bfmc_pkg::ext8(held_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]].g)
             + bfmc_pkg::ext8(p_q.g);
      hs.b = bfmc_pkg::ext8(held_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]].b)
             + bfmc_pkg::ext8(p_q.b);
      hs.a = bfmc_pkg::ext8(held_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]].a)
             + bfmc_pkg::ext8(p_q.a);
    end
    stop      = (k_q >= nlev) || (x >= dw) || (y >= dh) ||
                (w != DW'(1) && !c[0]) || (h != DW'(1) && !r[0]);
    store     = (k_q < nlev) && (x < dw) && (y < dh) &&
                (w == DW'(1) || c[0]) && h != DW'(1) && !r[0];
    need_read = h != DW'(1);
  end

  // pending horizontal pair sums of even rows
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [4*bfmc_pkg::HsumW-1:0] ram_rdata;
  assign ram_we    = (state_q == StStep) && store && (idx < (DW+1)'(MaxDim));
  assign ram_waddr = idx[AW-1:0];

  bfmc_ram #(.Width(4*bfmc_pkg::HsumW), .Depth(MaxDim)) u_sums (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(hs),
    .raddr_i(idx[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // read data is captured in the read state, before the ram output follows the moved address
  bfmc_pkg::hsum_t prev_q;
  bfmc_pkg::hsum_t prev;
  bfmc_pkg::pix_t  np;
  logic            is_done;
  always_comb begin
    prev = prev_q;
    if (h == DW'(1)) begin
      np.r = bfmc_pkg::avg(hs_q.r, hs_q.r);
      np.g = bfmc_pkg::avg(hs_q.g, hs_q.g);
      np.b = bfmc_pkg::avg(hs_q.b, hs_q.b);
      np.a = bfmc_pkg::avg(hs_q.a, hs_q.a);
    end else begin
      np.r = bfmc_pkg::avg(prev.r, hs_q.r);
      np.g = bfmc_pkg::avg(prev.g, hs_q.g);
      np.b = bfmc_pkg::avg(prev.b, hs_q.b);
      np.a = bfmc_pkg::avg(prev.a, hs_q.a);
    end
    is_done = (k_q + LW'(1) == nlev) && (x_q + DW'(1) == dw) && (y_q + DW'(1) == dh);
  end

  // the emitted pixel is held until the next level step decides last_of_run
  logic           pend_q;
  bfmc_pkg::res_t pres_q;
  logic           emit_now;
  assign emit_now = (state_q == StEmit);

  assign in_stall_o = (state_q != StIdle) || (pend_q && res_stall_i);

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = pres_q;
    if (pend_q) begin
      res_valid_o = (state_q == StIdle) || emit_now;
      res_o.last  = (state_q == StIdle);
    end
  end

  logic adv;
  assign adv = !(pend_q && res_valid_o && res_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i && !in_stall_o) state_d = StStep;
      StStep: if (stop) state_d = StIdle;
              else if (need_read) state_d = StRead;
              else state_d = StEmit;
      StRead: state_d = StEmit;
      StEmit: if (adv) state_d = StStep;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) p_q <= in_pix_i;
    if (state_q == StStep) begin
      hs_q <= hs;
      x_q  <= x;
      y_q  <= y;
      if (!stop || store || (w != DW'(1) && !c[0])) begin
        if (k_q < nlev && x < dw && y < dh && w != DW'(1) && !c[0])
          held_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]] <= p_q;
      end
    end
    if (state_q == StRead) prev_q <= bfmc_pkg::hsum_t'(ram_rdata);
    if (emit_now && adv) begin
      p_q <= np;
      pres_q.level  <= bfmc_pkg::LevelW'(k_q + LW'(1));
      pres_q.column <= x_q[bfmc_pkg::CoordW-1:0];
      pres_q.row    <= y_q[bfmc_pkg::CoordW-1:0];
      pres_q.pix    <= np;
      pres_q.last   <= 1'b0;
      pres_q.done   <= is_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      k_q       <= '0;
      pend_q    <= 1'b0;
      for (int i = 0; i < MaxLevels; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pend_q && res_valid_o && !res_stall_i) pend_q <= 1'b0;
      if (emit_now && adv) begin
        pend_q    <= 1'b1;
        k_q       <= k_q + LW'(1);
      end
      if (state_q == StIdle) k_q <= '0;
      if (state_q == StStep && k_q < nlev) begin
        if (c + DW'(1) >= w) begin
          col_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]] <= '0;
          row_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]] <=
            (r + DW'(1) >= h) ? '0 : r + DW'(1);
        end else begin
          col_q[k_q[$clog2(MaxLevels)-1+((MaxLevels==1)?1:0):0]] <= c + DW'(1);
        end
      end
      if (restart_i) begin
        for (int i = 0; i < MaxLevels; i++) begin
          col_q[i] <= '0;
          row_q[i] <= '0;
        end
      end
    end
  end
endmodule
